>>> design/cgrs_pkg.sv
// ---------------------------------------------------------------------------
// cgrs_pkg
// shared constants, codes and types of the cell grid range statistics block
// ---------------------------------------------------------------------------
package cgrs_pkg;

    // default geometry and value width
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // width of bounds limits, covers the largest supported grid side
    localparam int LIM_W = 11;

    // configuration registers
    localparam int        CFG_W      = 7;
    localparam logic      REG_ROWS   = 1'b0;
    localparam logic      REG_COLS   = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_AGG   = 2'd1;
    localparam logic [1:0] REQ_ARITH = 2'd2;

    // aggregate op codes
    localparam logic [2:0] AGG_SUM   = 3'd0;
    localparam logic [2:0] AGG_MIN   = 3'd1;
    localparam logic [2:0] AGG_MAX   = 3'd2;
    localparam logic [2:0] AGG_AVG   = 3'd3;
    localparam logic [2:0] AGG_STDEV = 3'd4;

    // arithmetic op codes
    localparam logic [2:0] AR_ADD = 3'd0;
    localparam logic [2:0] AR_SUB = 3'd1;
    localparam logic [2:0] AR_MUL = 3'd2;
    localparam logic [2:0] AR_DIV = 3'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOUNDS   = 2'd1;
    localparam logic [1:0] ST_REVERSED = 2'd2;
    localparam logic [1:0] ST_DIV0     = 2'd3;

    // iterative unit operations
    localparam logic [1:0] UOP_MUL  = 2'd0;
    localparam logic [1:0] UOP_DIV  = 2'd1;
    localparam logic [1:0] UOP_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } cgrs_ucmd_t;

endpackage

>>> design/cell_grid_range_statistics.sv
// ---------------------------------------------------------------------------
// cell_grid_range_statistics
// grid of signed cells in ram: literal writes, rectangular range aggregates
// (sum, min, max, avg, stdev) and two-operand arithmetic into a target cell
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  request fields, one transfer each
//  m_*       out        m_valid / m_ready  result_value, status, cells_covered
//  apb       in         psel/penable       rows_in_use at 0x0, cols_in_use at 0x4
//
//  after reset a clearing pass zeroes every ram cell, with s_ready low;
//  register writes are taken meanwhile
//  write literal, add, sub and mul finish in the sequencer; div runs in the
//  shared iterative unit; aggregate: one ram read per cell, then avg and stdev
//  also run in the shared iterative unit (XW=90 default)
//  one request at a time; s_ready is high only while idle, and a finished
//  result waits in the output register while the next request is taken
// ---------------------------------------------------------------------------
module cell_grid_range_statistics
    import cgrs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [2:0]         s_op_code,
    input  logic [5:0]         s_target_row,
    input  logic [5:0]         s_target_col,
    input  logic [5:0]         s_first_row,
    input  logic [5:0]         s_first_col,
    input  logic [5:0]         s_last_row,
    input  logic [5:0]         s_last_col,
    input  logic               s_a_is_literal,
    input  logic               s_b_is_literal,
    input  logic signed [31:0] s_literal_a,
    input  logic signed [31:0] s_literal_b,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status,
    output logic [12:0]        m_cells_covered,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int VW    = VALUE_WIDTH;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);   // cell count
    localparam int SW    = VW + CW;             // running sum
    localparam int QW    = 2 * VW + CW;         // running square sum
    localparam int XW    = 2 * SW;              // stdev intermediate

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_AGG   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_ARA   = 4'd6;
    localparam logic [3:0] S_ARB   = 4'd7;
    localparam logic [3:0] S_ARC   = 4'd8;
    localparam logic [3:0] S_ARX   = 4'd9;
    localparam logic [3:0] S_UNIT  = 4'd10;
    localparam logic [3:0] S_PUT   = 4'd11;

    // phases of work in the iterative unit
    localparam logic [2:0] PH_AVG = 3'd0;
    localparam logic [2:0] PH_SD1 = 3'd1;
    localparam logic [2:0] PH_SD2 = 3'd2;
    localparam logic [2:0] PH_SD3 = 3'd3;
    localparam logic [2:0] PH_SD4 = 3'd4;
    localparam logic [2:0] PH_DIV = 3'd5;

    function automatic logic in_bounds(input logic [5:0] r, input logic [5:0] c,
                                       input logic [LIM_W-1:0] lr,
                                       input logic [LIM_W-1:0] lc);
        return (LIM_W'(r) < lr) && (LIM_W'(c) < lc);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic [LIM_W-1:0] lim_rows, lim_cols;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_RESET;
            cols_reg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            // word addressed: bit 2 picks the register
            if (paddr[2] == REG_COLS) begin
                cols_reg <= pwdata[CFG_W-1:0];
            end else begin
                rows_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_reg) : 32'(rows_reg);

    // effective limits, clipped to the grid size
    assign lim_rows = (LIM_W'(rows_reg) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                            : LIM_W'(rows_reg);
    assign lim_cols = (LIM_W'(cols_reg) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                            : LIM_W'(cols_reg);

    // ---------------- registered request ----------------
    logic [1:0]           q_req_reg;
    logic [2:0]           q_op_reg;
    logic [5:0]           q_tr_reg, q_tc_reg, q_fr_reg, q_fc_reg, q_lr_reg, q_lc_reg;
    logic                 q_alit_reg, q_blit_reg;
    logic signed [VW-1:0] q_la_reg, q_lb_reg;

    // ---------------- sequencer state ----------------
    logic [3:0]           state_reg, state_next;
    logic [2:0]           phase_reg, phase_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [5:0]           wr_reg, wr_next, wc_reg, wc_next;
    logic                 rv_reg, rv_next;        // ram data valid this cycle
    logic                 pv_reg, pv_next;        // squared value valid
    logic signed [VW-1:0] v_reg, v_next;
    logic [2*VW-1:0]      sq_reg, sq_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [QW-1:0]        sumsq_reg, sumsq_next;
    logic signed [VW-1:0] min_reg, min_next, max_reg, max_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [XW-1:0]        p1_reg, p1_next;
    logic signed [VW-1:0] opa_reg, opa_next;      // arithmetic operands
    logic signed [VW-1:0] opb_reg, opb_next;
    logic                 neg_reg, neg_next;      // quotient sign
    logic signed [VW-1:0] res_val_reg, res_val_next;
    logic [1:0]           res_st_reg, res_st_next;
    logic [12:0]          res_cov_reg, res_cov_next;
    logic                 res_wr_reg, res_wr_next;
    // output register
    logic                 out_v_reg, out_v_next;
    logic signed [VW-1:0] out_val_reg, out_val_next;
    logic [1:0]           out_st_reg, out_st_next;
    logic [12:0]          out_cov_reg, out_cov_next;

    // ram and unit connections
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VW-1:0]        ram_wdata, ram_rdata;
    cgrs_ucmd_t           ucmd;
    logic [XW-1:0]        u_opa, u_opb, u_res;
    logic                 u_done;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        logic                 tgt_ok, fa_ok, lb_ok, reversed;
        logic signed [VW-1:0] rv;
        logic [VW-1:0]        mag;
        logic [SW-1:0]        sum_mag;
        logic [2*VW-1:0]      prod;
        logic [VW-1:0]        q;
        state_next   = state_reg;
        phase_next   = phase_reg;
        clr_next     = clr_reg;
        wr_next      = wr_reg;
        wc_next      = wc_reg;
        rv_next      = 1'b0;
        pv_next      = rv_reg;
        v_next       = v_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        n_next       = n_reg;
        p1_next      = p1_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        neg_next     = neg_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        res_cov_next = res_cov_reg;
        res_wr_next  = res_wr_reg;
        out_v_next   = out_v_reg && !m_ready;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        out_cov_next = out_cov_reg;
        ram_we       = 1'b0;
        ram_waddr    = cell_addr(q_tr_reg, q_tc_reg);
        ram_wdata    = res_val_reg;
        ram_raddr    = cell_addr(wr_reg, wc_reg);
        ucmd.start   = 1'b0;
        ucmd.op      = UOP_MUL;
        u_opa        = '0;
        u_opb        = '0;

        tgt_ok   = in_bounds(q_tr_reg, q_tc_reg, lim_rows, lim_cols);
        fa_ok    = in_bounds(q_fr_reg, q_fc_reg, lim_rows, lim_cols);
        lb_ok    = in_bounds(q_lr_reg, q_lc_reg, lim_rows, lim_cols);
        reversed = (q_fr_reg > q_lr_reg) || (q_fc_reg > q_lc_reg);
        rv       = $signed(ram_rdata);
        mag      = rv[VW-1] ? VW'(-rv) : VW'(rv);
        sum_mag  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        prod     = (2*VW)'(opa_reg) * (2*VW)'(opb_reg);
        q        = u_res[VW-1:0];

        // aggregate datapath: square after the ram read, accumulate after that
        if (rv_reg) begin
            v_next  = rv;
            sq_next = (2*VW)'(mag) * (2*VW)'(mag);
        end
        if (pv_reg) begin
            sum_next   = sum_reg + SW'(v_reg);
            sumsq_next = sumsq_reg + QW'(sq_reg);
            if (v_reg < min_reg) min_next = v_reg;
            if (v_reg > max_reg) max_next = v_reg;
            n_next     = n_reg + 1'b1;
        end

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                res_val_next = '0;
                res_st_next  = ST_OK;
                res_cov_next = '0;
                res_wr_next  = 1'b0;
                state_next   = S_PUT;
                case (q_req_reg)
                    REQ_WRITE: begin
                        if (!tgt_ok) begin
                            res_st_next = ST_BOUNDS;
                        end else begin
                            res_val_next = q_la_reg;
                            res_wr_next  = 1'b1;
                        end
                    end
                    REQ_AGG: begin
                        if (q_op_reg <= AGG_STDEV) begin
                            if (!tgt_ok) begin
                                res_st_next = ST_BOUNDS;
                            end else if (reversed) begin
                                res_st_next = ST_REVERSED;
                            end else if (!fa_ok || !lb_ok) begin
                                res_st_next = ST_BOUNDS;
                            end else begin
                                sum_next   = '0;
                                sumsq_next = '0;
                                min_next   = VAL_MAX;
                                max_next   = VAL_MIN;
                                n_next     = '0;
                                wr_next    = q_fr_reg;
                                wc_next    = q_fc_reg;
                                state_next = S_AGG;
                            end
                        end
                    end
                    REQ_ARITH: begin
                        if (q_op_reg <= AR_DIV) begin
                            if (!tgt_ok || (!q_alit_reg && !fa_ok) ||
                                (!q_blit_reg && !lb_ok)) begin
                                res_st_next = ST_BOUNDS;
                            end else begin
                                state_next = S_ARA;
                            end
                        end
                    end
                    default: begin
                        state_next = S_PUT;
                    end
                endcase
            end
            S_AGG: begin
                // one read per cycle, row by row
                rv_next = 1'b1;
                if (wc_reg == q_lc_reg) begin
                    wc_next = q_fc_reg;
                    wr_next = wr_reg + 1'b1;
                    if (wr_reg == q_lr_reg) state_next = S_DRAIN;
                end else begin
                    wc_next = wc_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!rv_reg && !pv_reg) state_next = S_FIN;
            end
            S_FIN: begin
                res_cov_next = 13'(n_reg);
                res_wr_next  = 1'b1;
                state_next   = S_PUT;
                case (q_op_reg)
                    AGG_SUM: res_val_next = sum_reg[VW-1:0];
                    AGG_MIN: res_val_next = min_reg;
                    AGG_MAX: res_val_next = max_reg;
                    AGG_AVG: begin
                        ucmd.start = 1'b1;
                        ucmd.op    = UOP_DIV;
                        u_opa      = XW'(sum_mag);
                        u_opb      = XW'(n_reg);
                        neg_next   = sum_reg[SW-1];
                        phase_next = PH_AVG;
                        state_next = S_UNIT;
                    end
                    default: begin
                        ucmd.start = 1'b1;
                        ucmd.op    = UOP_MUL;
                        u_opa      = XW'(sumsq_reg);
                        u_opb      = XW'(n_reg);
                        phase_next = PH_SD1;
                        state_next = S_UNIT;
                    end
                endcase
            end
            S_ARA: begin
                ram_raddr  = cell_addr(q_fr_reg, q_fc_reg);
                state_next = S_ARB;
            end
            S_ARB: begin
                ram_raddr  = cell_addr(q_lr_reg, q_lc_reg);
                opa_next   = q_alit_reg ? q_la_reg : rv;
                state_next = S_ARC;
            end
            S_ARC: begin
                opb_next   = q_blit_reg ? q_lb_reg : rv;
                state_next = S_ARX;
            end
            S_ARX: begin
                res_wr_next = 1'b1;
                state_next  = S_PUT;
                case (q_op_reg)
                    AR_ADD: res_val_next = opa_reg + opb_reg;
                    AR_SUB: res_val_next = opa_reg - opb_reg;
                    AR_MUL: res_val_next = prod[VW-1:0];
                    default: begin
                        if (opb_reg == '0) begin
                            res_st_next = ST_DIV0;
                            res_wr_next = 1'b0;
                        end else begin
                            ucmd.start = 1'b1;
                            ucmd.op    = UOP_DIV;
                            u_opa      = XW'(opa_reg[VW-1] ? VW'(-opa_reg) : VW'(opa_reg));
                            u_opb      = XW'(opb_reg[VW-1] ? VW'(-opb_reg) : VW'(opb_reg));
                            neg_next   = opa_reg[VW-1] ^ opb_reg[VW-1];
                            phase_next = PH_DIV;
                            state_next = S_UNIT;
                        end
                    end
                endcase
            end
            S_UNIT: begin
                if (u_done) begin
                    case (phase_reg)
                        PH_SD1: begin
                            // n * sumsq done, now sum squared
                            p1_next    = u_res;
                            ucmd.start = 1'b1;
                            ucmd.op    = UOP_MUL;
                            u_opa      = XW'(sum_mag);
                            u_opb      = XW'(sum_mag);
                            phase_next = PH_SD2;
                        end
                        PH_SD2: begin
                            ucmd.start = 1'b1;
                            ucmd.op    = UOP_SQRT;
                            u_opa      = p1_reg - u_res;
                            phase_next = PH_SD3;
                        end
                        PH_SD3: begin
                            ucmd.start = 1'b1;
                            ucmd.op    = UOP_DIV;
                            u_opa      = u_res;
                            u_opb      = XW'(n_reg);
                            phase_next = PH_SD4;
                        end
                        PH_SD4: begin
                            res_val_next = $signed(q);
                            state_next   = S_PUT;
                        end
                        default: begin
                            // avg and div: signed quotient from magnitudes
                            res_val_next = neg_reg ? $signed(-q) : $signed(q);
                            state_next   = S_PUT;
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (!out_v_reg || m_ready) begin
                    out_v_next   = 1'b1;
                    out_val_next = res_wr_reg ? res_val_reg : '0;
                    out_st_next  = res_st_reg;
                    out_cov_next = res_cov_reg;
                    ram_we       = res_wr_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            phase_reg <= PH_AVG;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            pv_reg    <= pv_next;
            out_v_reg <= out_v_next;
            phase_reg <= phase_next;
        end
        // capture the request on its transfer
        if (s_valid && s_ready) begin
            q_req_reg  <= s_req_type;
            q_op_reg   <= s_op_code;
            q_tr_reg   <= s_target_row;
            q_tc_reg   <= s_target_col;
            q_fr_reg   <= s_first_row;
            q_fc_reg   <= s_first_col;
            q_lr_reg   <= s_last_row;
            q_lc_reg   <= s_last_col;
            q_alit_reg <= s_a_is_literal;
            q_blit_reg <= s_b_is_literal;
            q_la_reg   <= s_literal_a[VW-1:0];
            q_lb_reg   <= s_literal_b[VW-1:0];
        end
        wr_reg      <= wr_next;
        wc_reg      <= wc_next;
        v_reg       <= v_next;
        sq_reg      <= sq_next;
        sum_reg     <= sum_next;
        sumsq_reg   <= sumsq_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        n_reg       <= n_next;
        p1_reg      <= p1_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        neg_reg     <= neg_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        res_cov_reg <= res_cov_next;
        res_wr_reg  <= res_wr_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_cov_reg <= out_cov_next;
    end

    // cell store
    cgrs_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiply / divide / square root
    cgrs_iter #(
        .XW (XW)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ucmd),
        .opa     (u_opa),
        .opb     (u_opb),
        .done    (u_done),
        .result  (u_res)
    );

    assign m_valid         = out_v_reg;
    assign m_result_value  = 32'(out_val_reg);
    assign m_status        = out_st_reg;
    assign m_cells_covered = out_cov_reg;

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_CHECK)
        else $error("accepted request not decoded");
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> m_result_value == 32'sd0)
        else $error("error result carries a nonzero value");
    a_walk_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (rv_reg || pv_reg) |-> (state_reg == S_AGG || state_reg == S_DRAIN))
        else $error("aggregate pipeline active outside the walk");
    a_write_put: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || (state_reg == S_PUT && res_st_reg == ST_OK)))
        else $error("cell write outside clearing or a good result");

endmodule

>>> design/cgrs_ram.sv
// ---------------------------------------------------------------------------
// cgrs_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module cgrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cgrs_iter.sv
// ---------------------------------------------------------------------------
// cgrs_iter
// shared iterative unit: shift-add multiply, restoring divide, digit isqrt
// ---------------------------------------------------------------------------
module cgrs_iter
    import cgrs_pkg::*;
#(
    parameter int XW = 90
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cgrs_ucmd_t    cmd,
    input  logic [XW-1:0] opa,
    input  logic [XW-1:0] opb,
    output logic          done,
    output logic [XW-1:0] result
);

    localparam int CNTW = $clog2(XW + 1);

    logic [XW-1:0]   x_reg, x_next;
    logic [XW+1:0]   y_reg, y_next;
    logic [XW-1:0]   z_reg, z_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [1:0]      op_reg, op_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb begin
        logic [XW:0]   t_div;
        logic [XW+1:0] t_sq;
        logic [XW+1:0] trial;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        t_div     = {y_reg[XW-1:0], x_reg[XW-1]};
        t_sq      = {y_reg[XW-1:0], x_reg[XW-1 -: 2]};
        trial     = {z_reg, 2'b01};
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = (cmd.op == UOP_SQRT) ? CNTW'(XW / 2) : CNTW'(XW);
            y_next    = '0;
            case (cmd.op)
                UOP_DIV: begin
                    x_next = opa;
                    z_next = opb;
                end
                UOP_SQRT: begin
                    x_next = opa;
                    z_next = '0;
                end
                default: begin
                    x_next = opb;
                    z_next = opa;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                UOP_DIV: begin
                    if (t_div >= {1'b0, z_reg}) begin
                        y_next = {1'b0, t_div - {1'b0, z_reg}};
                        x_next = {x_reg[XW-2:0], 1'b1};
                    end else begin
                        y_next = {1'b0, t_div};
                        x_next = {x_reg[XW-2:0], 1'b0};
                    end
                end
                UOP_SQRT: begin
                    x_next = x_reg << 2;
                    if (t_sq >= trial) begin
                        y_next = t_sq - trial;
                        z_next = {z_reg[XW-2:0], 1'b1};
                    end else begin
                        y_next = t_sq;
                        z_next = {z_reg[XW-2:0], 1'b0};
                    end
                end
                default: begin
                    if (x_reg[0]) begin
                        y_next = y_reg + (XW+2)'(z_reg);
                    end
                    z_next = z_reg << 1;
                    x_next = x_reg >> 1;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= UOP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb begin
        case (op_reg)
            UOP_DIV:  result = x_reg;
            UOP_SQRT: result = z_reg;
            default:  result = y_reg[XW-1:0];
        endcase
    end

    assign done = done_reg;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("iterative unit started while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done raised while unit still busy");
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("unit busy with zero step count");

endmodule
